### rtl/core/rotation_matrix_to_quaternion_assert.svh
// Assertion macros for the rotation matrix to quaternion block.
`ifndef ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH

// Same-cycle implication, off during reset
`define RMQ_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rmq: check failed");

// Next-cycle implication, checked during reset too
`define RMQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("rmq: check failed");

`endif

### rtl/core/rmq_pkg.sv
// Shared types and constants of the rotation matrix to quaternion block.
package rmq_pkg;

    localparam int DW     = 16;  // width of every matrix entry and component
    localparam int DIF_W  = 17;  // exact sum or difference of two entries
    localparam int QB     = 17;  // quotient bits kept by the divider

    localparam logic signed [DW-1:0] OUT_MAX = 16'sh7FFF;
    localparam logic signed [DW-1:0] OUT_MIN = 16'sh8000;

    typedef enum logic [1:0] {
        CASE_TRACE = 2'd0,
        CASE_X     = 2'd1,
        CASE_Y     = 2'd2,
        CASE_Z     = 2'd3
    } t_case;

    // Apply the sign to a quotient magnitude and clamp to 16 bits
    function automatic logic signed [DW-1:0] sat_quot(input logic neg, input logic ovf,
                                                      input logic [QB-1:0] q);
        logic signed [DW-1:0] res;
        if (neg) begin
            if (ovf || q > QB'(32768)) res = OUT_MIN;
            else                       res = DW'(-$signed({1'b0, q}));
        end else begin
            if (ovf || q > QB'(32767)) res = OUT_MAX;
            else                       res = DW'(q);
        end
        return res;
    endfunction

endpackage

### rtl/core/rotation_matrix_to_quaternion.sv
// Rotation matrix to quaternion conversion, Shepperd branch selection, fixed point.
//
// Slave channel: one 3x3 matrix per beat, nine signed Q2.14 entries in tdata,
// m00 in the lowest 16 bits, row-major. Master channel: quaternion w,x,y,z in
// tdata, case taken and invalid flag in tuser.
// The datapath is a pipeline of P+22 register stages, P = ceil((A+F+2)/2)
// with F = FRAC_BITS and A = max(F,17)+2: decode, P square root digit stages
// (both roots side by side, one result bit each), root rounding, numerator
// build, overflow check, 17 restoring divider stages (the three divisions run
// side by side) and the output register. With FRAC_BITS = 14 there are 40
// stages.
// Throughput is one matrix per cycle. Each stage holds when it is full and the
// stage after it does not move, so bubbles collapse and a stalled receiver
// only stops the input once every stage is full. Nothing is lost or repeated.
// A synchronous low reset empties all stages; data registers keep no reset.
module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = 14
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22 (16 bits each)
    input  logic [143:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // quat_w, quat_x, quat_y, quat_z (16 bits each)
    output logic [63:0]  o_m_tdata,
    // case_taken [1:0], invalid [2]
    output logic [2:0]   o_m_tuser
);
    import rmq_pkg::*;

    localparam int F    = FRAC_BITS;
    localparam int AB   = ((F > 17) ? F : 17) + 2;   // positive argument bits
    localparam int AS   = AB + 1;                     // signed argument width
    localparam int NB   = AB + F + 2;
    localparam int P    = (NB + 1) / 2;               // root digit stages
    localparam int RW   = P;
    localparam int REMW = P + 2;
    localparam int SW   = P + 1;                      // rounded root width
    localparam int DNW  = P + 2;                      // divisor 2*S
    localparam int NNW  = DW + F + 2;                 // rounded numerator
    localparam int CW   = (NNW > DNW + QB) ? NNW : DNW + QB;
    localparam int RND  = P + 1;
    localparam int NUM  = P + 2;
    localparam int OVF  = P + 3;
    localparam int DVN  = P + 3 + QB;
    localparam int OUTS = DVN + 1;
    localparam int L    = OUTS + 1;

    // stage valid bits and ready chain
    logic [L-1:0] r_v;
    logic [L:0]   w_rdy;
    logic [L-1:0] w_vin;

    assign w_rdy[L] = i_m_tready;
    genvar gk;
    generate
        for (gk = 0; gk < L; gk++) begin : g_rdy
            assign w_rdy[gk] = ~r_v[gk] | w_rdy[gk+1];
        end
    endgenerate
    assign w_vin = {r_v[L-2:0], i_s_tvalid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < L; k++) begin
                if (w_rdy[k]) r_v[k] <= w_vin[k];
            end
        end
    end

    assign o_s_tready = w_rdy[0];

    // sideband carried through every stage
    t_case r_case [0:L-1];
    logic  r_inv  [0:L-1];

    generate
        for (gk = 1; gk < L; gk++) begin : g_side
            always_ff @(posedge i_clk) begin
                if (w_rdy[gk]) begin
                    r_case[gk] <= r_case[gk-1];
                    r_inv[gk]  <= r_inv[gk-1];
                end
            end
        end
    endgenerate

    // decode: trace, branch, argument and the three off-diagonal terms
    logic signed [DW-1:0]    w_m [0:8];
    logic signed [AS-1:0]    w_e00, w_e11, w_e22, w_tr, w_arg;
    logic signed [DIF_W-1:0] w_d [0:2];
    t_case                   w_case;
    logic                    w_inv;
    logic [AB-1:0]           w_argu;

    always_comb begin
        for (int i = 0; i < 9; i++) w_m[i] = $signed(i_s_tdata[i*DW +: DW]);
        w_e00 = AS'(w_m[0]);
        w_e11 = AS'(w_m[4]);
        w_e22 = AS'(w_m[8]);
        w_tr  = w_e00 + w_e11 + w_e22;
        if (w_tr > 0) begin
            w_case = CASE_TRACE;
            w_arg  = (AS'(1) <<< F) + w_tr;
            w_d[0] = DIF_W'(w_m[7]) - DIF_W'(w_m[5]);
            w_d[1] = DIF_W'(w_m[2]) - DIF_W'(w_m[6]);
            w_d[2] = DIF_W'(w_m[3]) - DIF_W'(w_m[1]);
        end else if (w_m[0] > w_m[4] && w_m[0] > w_m[8]) begin
            w_case = CASE_X;
            w_arg  = (AS'(1) <<< F) + w_e00 - w_e11 - w_e22;
            w_d[0] = DIF_W'(w_m[7]) - DIF_W'(w_m[5]);
            w_d[1] = DIF_W'(w_m[1]) + DIF_W'(w_m[3]);
            w_d[2] = DIF_W'(w_m[2]) + DIF_W'(w_m[6]);
        end else if (w_m[4] > w_m[8]) begin
            w_case = CASE_Y;
            w_arg  = (AS'(1) <<< F) + w_e11 - w_e00 - w_e22;
            w_d[0] = DIF_W'(w_m[2]) - DIF_W'(w_m[6]);
            w_d[1] = DIF_W'(w_m[1]) + DIF_W'(w_m[3]);
            w_d[2] = DIF_W'(w_m[5]) + DIF_W'(w_m[7]);
        end else begin
            w_case = CASE_Z;
            w_arg  = (AS'(1) <<< F) + w_e22 - w_e00 - w_e11;
            w_d[0] = DIF_W'(w_m[3]) - DIF_W'(w_m[1]);
            w_d[1] = DIF_W'(w_m[2]) + DIF_W'(w_m[6]);
            w_d[2] = DIF_W'(w_m[5]) + DIF_W'(w_m[7]);
        end
        w_inv  = (w_arg <= 0);
        w_argu = w_inv ? '0 : w_arg[AB-1:0];
    end

    // square root digit stages, index 0 is the decode register
    logic [2*P-1:0]          r_n1   [0:P];
    logic [2*P-1:0]          r_n2   [0:P];
    logic [REMW-1:0]         r_rem1 [0:P];
    logic [REMW-1:0]         r_rem2 [0:P];
    logic [RW-1:0]           r_rt1  [0:P];
    logic [RW-1:0]           r_rt2  [0:P];
    logic signed [DIF_W-1:0] r_dif  [0:P][0:2];

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_case[0] <= w_case;
            r_inv[0]  <= w_inv;
            r_n1[0]   <= (2*P)'(w_argu) << (F + 2);
            r_n2[0]   <= (2*P)'(w_argu) << (F - 2);
            r_rem1[0] <= '0;
            r_rem2[0] <= '0;
            r_rt1[0]  <= '0;
            r_rt2[0]  <= '0;
            for (int j = 0; j < 3; j++) r_dif[0][j] <= w_d[j];
        end
    end

    generate
        for (gk = 1; gk <= P; gk++) begin : g_sqrt
            logic [REMW-1:0] w_sh1, w_sh2, w_tr1, w_tr2;
            always_comb begin
                w_sh1 = {r_rem1[gk-1][REMW-3:0], r_n1[gk-1][2*P-1 -: 2]};
                w_sh2 = {r_rem2[gk-1][REMW-3:0], r_n2[gk-1][2*P-1 -: 2]};
                w_tr1 = {r_rt1[gk-1], 2'b01};
                w_tr2 = {r_rt2[gk-1], 2'b01};
            end
            always_ff @(posedge i_clk) begin
                if (w_rdy[gk]) begin
                    r_n1[gk] <= r_n1[gk-1] << 2;
                    r_n2[gk] <= r_n2[gk-1] << 2;
                    if (w_sh1 >= w_tr1) begin
                        r_rem1[gk] <= w_sh1 - w_tr1;
                        r_rt1[gk]  <= {r_rt1[gk-1][RW-2:0], 1'b1};
                    end else begin
                        r_rem1[gk] <= w_sh1;
                        r_rt1[gk]  <= {r_rt1[gk-1][RW-2:0], 1'b0};
                    end
                    if (w_sh2 >= w_tr2) begin
                        r_rem2[gk] <= w_sh2 - w_tr2;
                        r_rt2[gk]  <= {r_rt2[gk-1][RW-2:0], 1'b1};
                    end else begin
                        r_rem2[gk] <= w_sh2;
                        r_rt2[gk]  <= {r_rt2[gk-1][RW-2:0], 1'b0};
                    end
                    for (int j = 0; j < 3; j++) r_dif[gk][j] <= r_dif[gk-1][j];
                end
            end
        end
    endgenerate

    // rounding of both roots, magnitudes of the terms (up to 2^16)
    logic [SW-1:0]    r_s;
    logic [SW-1:0]    r_big [RND:DVN];
    logic [2:0]       r_neg [RND:DVN];
    logic [DIF_W-1:0] r_mag [0:2];

    always_ff @(posedge i_clk) begin
        if (w_rdy[RND]) begin
            r_s        <= SW'(r_rt1[P]) + SW'(REMW'(r_rem1[P]) > REMW'(r_rt1[P]));
            r_big[RND] <= SW'(r_rt2[P]) + SW'(REMW'(r_rem2[P]) > REMW'(r_rt2[P]));
            for (int j = 0; j < 3; j++) begin
                r_neg[RND][j] <= r_dif[P][j][DIF_W-1];
                r_mag[j]      <= r_dif[P][j][DIF_W-1] ? DIF_W'(-r_dif[P][j])
                                                      : DIF_W'(r_dif[P][j]);
            end
        end
    end

    // numerator 2*|D|*2^F + S and divisor 2*S
    logic [NNW-1:0] r_num [0:2];
    logic [DNW-1:0] r_den [NUM:DVN];

    always_ff @(posedge i_clk) begin
        if (w_rdy[NUM]) begin
            r_den[NUM] <= {r_s, 1'b0};
            r_big[NUM] <= r_big[RND];
            r_neg[NUM] <= r_neg[RND];
            for (int j = 0; j < 3; j++) begin
                r_num[j] <= (NNW'(r_mag[j]) << (F + 1)) + NNW'(r_s);
            end
        end
    end

    // overflow check: quotient would not fit the kept bits
    logic [NNW-1:0] r_rem [OVF:DVN][0:2];
    logic [QB-1:0]  r_q   [OVF:DVN][0:2];
    logic [2:0]     r_ovf [OVF:DVN];

    always_ff @(posedge i_clk) begin
        if (w_rdy[OVF]) begin
            r_den[OVF] <= r_den[NUM];
            r_big[OVF] <= r_big[NUM];
            r_neg[OVF] <= r_neg[NUM];
            for (int j = 0; j < 3; j++) begin
                r_ovf[OVF][j] <= CW'(r_num[j]) >= (CW'(r_den[NUM]) << QB);
                r_rem[OVF][j] <= r_num[j];
                r_q[OVF][j]   <= '0;
            end
        end
    end

    // restoring divider, one quotient bit per stage
    generate
        for (gk = OVF + 1; gk <= DVN; gk++) begin : g_div
            localparam int SH = DVN - gk;
            logic [CW-1:0] w_dsh;
            assign w_dsh = CW'(r_den[gk-1]) << SH;
            always_ff @(posedge i_clk) begin
                if (w_rdy[gk]) begin
                    r_den[gk] <= r_den[gk-1];
                    r_big[gk] <= r_big[gk-1];
                    r_neg[gk] <= r_neg[gk-1];
                    r_ovf[gk] <= r_ovf[gk-1];
                    for (int j = 0; j < 3; j++) begin
                        if (CW'(r_rem[gk-1][j]) >= w_dsh) begin
                            r_rem[gk][j] <= NNW'(CW'(r_rem[gk-1][j]) - w_dsh);
                            r_q[gk][j]   <= r_q[gk-1][j] | (QB'(1) << SH);
                        end else begin
                            r_rem[gk][j] <= r_rem[gk-1][j];
                            r_q[gk][j]   <= r_q[gk-1][j];
                        end
                    end
                end
            end
        end
    endgenerate

    // saturate, place the largest component, clear on invalid
    logic signed [DW-1:0] w_qa [0:2];
    logic signed [DW-1:0] w_g;
    logic signed [DW-1:0] w_o [0:3];
    logic [DW-1:0]        r_out [0:3];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_qa[j] = sat_quot(r_neg[DVN][j], r_ovf[DVN][j], r_q[DVN][j]);
        end
        w_g = (r_big[DVN] > SW'(32767)) ? OUT_MAX : DW'(r_big[DVN]);
        case (r_case[DVN])
            CASE_TRACE: begin
                w_o[0] = w_g;     w_o[1] = w_qa[0]; w_o[2] = w_qa[1]; w_o[3] = w_qa[2];
            end
            CASE_X: begin
                w_o[0] = w_qa[0]; w_o[1] = w_g;     w_o[2] = w_qa[1]; w_o[3] = w_qa[2];
            end
            CASE_Y: begin
                w_o[0] = w_qa[0]; w_o[1] = w_qa[1]; w_o[2] = w_g;     w_o[3] = w_qa[2];
            end
            default: begin
                w_o[0] = w_qa[0]; w_o[1] = w_qa[1]; w_o[2] = w_qa[2]; w_o[3] = w_g;
            end
        endcase
        if (r_inv[DVN]) begin
            for (int j = 0; j < 4; j++) w_o[j] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[OUTS]) begin
            for (int j = 0; j < 4; j++) r_out[j] <= w_o[j];
        end
    end

    // master channel
    assign o_m_tvalid = r_v[OUTS];
    assign o_m_tdata  = {r_out[3], r_out[2], r_out[1], r_out[0]};
    assign o_m_tuser  = {r_inv[OUTS], r_case[OUTS]};

    // checks
    `include "rotation_matrix_to_quaternion_assert.svh"

    `RMQ_ASSERT_IMPL(a_inv_zero, o_m_tvalid && o_m_tuser[2], o_m_tdata == 64'd0)
    `RMQ_ASSERT_IMPL(a_trace_w_pos, o_m_tvalid && !o_m_tuser[2] && o_m_tuser[1:0] == CASE_TRACE, o_m_tdata[15] == 1'b0 && o_m_tdata[15:0] != 16'd0)
    `RMQ_ASSERT_IMPL(a_ready_gap, !r_v[OUTS], o_s_tready)
    `RMQ_ASSERT_NEXT(a_reset_empty, !i_rst_n, !o_m_tvalid)

endmodule
